// File: hw/rtl/mm3_pkg.sv
// Shared types, constants and helper functions for the MurmurHash3 x64-128 stream hasher.
package mm3_pkg;

   // Default width of the running byte counter.
   localparam int LengthBitsDefault = 32;

   // Seed after reset and the largest length a C int holds.
   localparam logic [31:0] HashSeedReset = 32'd10457;
   localparam logic [63:0] IntMaxLen     = 64'h0000_0000_7fff_ffff;

   // Block mixing and finalizer constants.
   localparam logic [63:0] MixC1  = 64'h87c3_7b91_1142_53d5;
   localparam logic [63:0] MixC2  = 64'h4cf5_ad43_2745_937f;
   localparam logic [63:0] AddOne = 64'h0000_0000_52dc_e729;
   localparam logic [63:0] AddTwo = 64'h0000_0000_3849_5ab5;
   localparam logic [63:0] FinM1  = 64'hff51_afd7_ed55_8ccd;
   localparam logic [63:0] FinM2  = 64'hc4ce_b9fe_1a85_ec53;

   // Multiplier step codes: low partial product, then the two cross terms.
   localparam logic [1:0] MulStepLow    = 2'd0;
   localparam logic [1:0] MulStepCrossA = 2'd1;
   localparam logic [1:0] MulStepCrossB = 2'd2;

   // Request and response payloads.
   typedef struct packed {
      logic [63:0] low_word;
      logic [63:0] high_word;
      logic [4:0]  byte_count;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [63:0] hash_low;
      logic [63:0] hash_high;
      logic        too_long;
   } rsp_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL,
      OP_ROT,
      OP_MIX1,
      OP_MIX2,
      OP_TAIL,
      OP_FIN_A,
      OP_FIN_B,
      OP_FMIX_LD,
      OP_FMIX_MID,
      OP_FMIX_END,
      OP_FIN_C,
      OP_FIN_D,
      OP_EMIT
   } op_type;

   // Multiplier constant pairs (lane one, lane two).
   typedef enum logic [1:0] {
      KSEL_R1,
      KSEL_R2,
      KSEL_F1,
      KSEL_F2
   } ksel_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] step;
      ksel_type   ksel;
   } cmd_type;

   typedef struct packed {
      logic is_full;
      logic is_last;
   } status_type;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_K1,
      S_ROT,
      S_K2,
      S_APPLY,
      S_MIX2,
      S_FIN_A,
      S_FIN_B,
      S_FLD,
      S_F1,
      S_FMID,
      S_F2,
      S_FEND,
      S_FIN_C,
      S_FIN_D,
      S_EMIT
   } state_type;

   // Rotate a 64-bit word left by a fixed amount.
   function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
      return (x << r) | (x >> (64 - r));
   endfunction

   // Mask of the low n bytes of a word, n from 0 to 8.
   function automatic logic [63:0] byte_mask(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < n) begin
            m[8*i +: 8] = 8'hff;
         end
      end
      return m;
   endfunction

   // x * 5 + c as a shift and two adds.
   function automatic logic [63:0] mul5_add(input logic [63:0] x, input logic [63:0] c);
      return x + (x << 2) + c;
   endfunction

   // Pre-multiply step of fmix64.
   function automatic logic [63:0] fold33(input logic [63:0] x);
      return x ^ (x >> 33);
   endfunction

endpackage

// File: hw/rtl/mm3_mul.sv
// Three-step 64 by 64 multiplier that keeps the low 64 bits of the product.
module mm3_mul (
   input  logic        clock,
   input  logic        enable,
   input  logic [1:0]  step,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic [63:0] product
);
   import mm3_pkg::*;

   logic [31:0] mul_x;
   logic [31:0] mul_y;
   logic [63:0] partial;
   logic [63:0] acc_ff;
   logic [63:0] acc_in;

   // Pick the 32-bit halves for this step; one 32x32 multiplier does all three.
   always_comb begin
      mul_x = op_a[31:0];
      mul_y = op_b[31:0];
      case (step)
         MulStepCrossA: begin
            mul_y = op_b[63:32];
         end
         MulStepCrossB: begin
            mul_x = op_a[63:32];
         end
         default: begin
         end
      endcase
      partial = 64'(mul_x) * 64'(mul_y);
   end

   // Accumulate: the cross terms only add into the upper half.
   always_comb begin
      acc_in = acc_ff;
      if (enable) begin
         case (step)
            MulStepLow: begin
               acc_in = partial;
            end
            MulStepCrossA, MulStepCrossB: begin
               acc_in = acc_ff + {partial[31:0], 32'd0};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign product = acc_ff;

endmodule

// File: hw/rtl/mm3_datapath.sv
// Hash lanes, byte counter, seed register, operand registers and result register.
module mm3_datapath #(
   parameter int LENGTH_BITS = mm3_pkg::LengthBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  mm3_pkg::cmd_type    cmd,
   output mm3_pkg::status_type status,
   input  mm3_pkg::req_type    req_data,
   input  logic               seed_write,
   input  logic [31:0]        seed_data,
   output mm3_pkg::rsp_type    rsp_data
);
   import mm3_pkg::*;

   localparam int SumBits = LENGTH_BITS + 1;

   logic [31:0]            seed_ff;
   logic [63:0]            lane1_ff, lane1_in;
   logic [63:0]            lane2_ff, lane2_in;
   logic [63:0]            opa1_ff, opa1_in;
   logic [63:0]            opa2_ff, opa2_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic                   full_ff, full_in;
   logic                   last_ff, last_in;
   rsp_type                rsp_ff, rsp_in;

   logic [4:0]         n_eff;
   logic               in_full;
   logic [63:0]        tail1;
   logic [63:0]        tail2;
   logic [SumBits-1:0] sum;
   logic [63:0]        len64;
   logic [63:0]        konst1;
   logic [63:0]        konst2;
   logic [63:0]        prod1;
   logic [63:0]        prod2;
   logic               mul_en;
   logic [63:0]        lane1_x;
   logic [63:0]        lane2_x;

   // Effective byte count: anything not last, or above sixteen, is a full block.
   always_comb begin
      if (!req_data.last || req_data.byte_count > 5'd16) begin
         n_eff = 5'd16;
      end else begin
         n_eff = req_data.byte_count;
      end
      in_full = (n_eff == 5'd16);
      tail1   = req_data.low_word & byte_mask((n_eff > 5'd8) ? 4'd8 : n_eff[3:0]);
      if (n_eff > 5'd8) begin
         tail2 = req_data.high_word & byte_mask(4'(n_eff - 5'd8));
      end else begin
         tail2 = '0;
      end
      sum   = {1'b0, count_ff} + SumBits'(n_eff);
      len64 = 64'(count_ff);
   end

   // Multiplier constants for each round.
   always_comb begin
      unique case (cmd.ksel)
         KSEL_R1: begin konst1 = MixC1; konst2 = MixC2; end
         KSEL_R2: begin konst1 = MixC2; konst2 = MixC1; end
         KSEL_F1: begin konst1 = FinM1; konst2 = FinM1; end
         KSEL_F2: begin konst1 = FinM2; konst2 = FinM2; end
         default: begin konst1 = MixC1; konst2 = MixC2; end
      endcase
   end

   assign mul_en = (cmd.op == OP_MUL);

   mm3_mul u_mul1 (
      .clock   (clock),
      .enable  (mul_en),
      .step    (cmd.step),
      .op_a    (opa1_ff),
      .op_b    (konst1),
      .product (prod1)
   );

   mm3_mul u_mul2 (
      .clock   (clock),
      .enable  (mul_en),
      .step    (cmd.step),
      .op_a    (opa2_ff),
      .op_b    (konst2),
      .product (prod2)
   );

   // Lane and operand updates per operation.
   always_comb begin
      lane1_in = lane1_ff;
      lane2_in = lane2_ff;
      opa1_in  = opa1_ff;
      opa2_in  = opa2_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      full_in  = full_ff;
      last_in  = last_ff;
      rsp_in   = rsp_ff;
      lane1_x  = lane1_ff ^ len64;
      lane2_x  = lane2_ff ^ len64;
      unique case (cmd.op)
         OP_LOAD: begin
            // A fresh string starts from the seed.
            if (count_ff == '0 && !ovf_ff) begin
               lane1_in = 64'(seed_ff);
               lane2_in = 64'(seed_ff);
            end
            opa1_in  = in_full ? req_data.low_word : tail1;
            opa2_in  = in_full ? req_data.high_word : tail2;
            full_in  = in_full;
            last_in  = req_data.last;
            count_in = sum[LENGTH_BITS-1:0];
            if (sum[LENGTH_BITS] || 65'(sum) > 65'(IntMaxLen)) begin
               ovf_in = 1'b1;
            end
         end
         OP_ROT: begin
            opa1_in = rotl64(prod1, 31);
            opa2_in = rotl64(prod2, 33);
         end
         OP_MIX1: begin
            lane1_in = mul5_add(rotl64(lane1_ff ^ prod1, 27) + lane2_ff, AddOne);
         end
         OP_MIX2: begin
            lane2_in = mul5_add(rotl64(lane2_ff ^ prod2, 31) + lane1_ff, AddTwo);
         end
         OP_TAIL: begin
            // Unused tail words were zero, so their mixed key is zero too.
            lane1_in = lane1_ff ^ prod1;
            lane2_in = lane2_ff ^ prod2;
         end
         OP_FIN_A: begin
            lane1_in = lane1_x + lane2_x;
            lane2_in = lane2_x;
         end
         OP_FIN_B: begin
            lane2_in = lane2_ff + lane1_ff;
         end
         OP_FMIX_LD: begin
            opa1_in = fold33(lane1_ff);
            opa2_in = fold33(lane2_ff);
         end
         OP_FMIX_MID: begin
            opa1_in = fold33(prod1);
            opa2_in = fold33(prod2);
         end
         OP_FMIX_END: begin
            lane1_in = fold33(prod1);
            lane2_in = fold33(prod2);
         end
         OP_FIN_C: begin
            lane1_in = lane1_ff + lane2_ff;
         end
         OP_FIN_D: begin
            lane2_in = lane2_ff + lane1_ff;
         end
         OP_EMIT: begin
            rsp_in.hash_low  = lane1_ff;
            rsp_in.hash_high = lane2_ff;
            rsp_in.too_long  = ovf_ff;
            count_in         = '0;
            ovf_in           = 1'b0;
         end
         OP_NONE, OP_MUL: begin
         end
         default: begin
         end
      endcase
   end

   // Control state: seed, count and overflow flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= HashSeedReset;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         if (seed_write) begin
            seed_ff <= seed_data;
         end
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lane1_ff <= lane1_in;
      lane2_ff <= lane2_in;
      opa1_ff  <= opa1_in;
      opa2_ff  <= opa2_in;
      full_ff  <= full_in;
      last_ff  <= last_in;
      rsp_ff   <= rsp_in;
   end

   assign status.is_full = full_ff;
   assign status.is_last = last_ff;
   assign rsp_data       = rsp_ff;

endmodule

// File: hw/rtl/mm3_ctrl.sv
// Controller state machine that sequences the hash datapath and owns the handshakes.
module mm3_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  mm3_pkg::status_type status,
   output mm3_pkg::cmd_type    cmd
);
   import mm3_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       emit;

   // Next state and datapath command.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd.op    = OP_NONE;
      cmd.step  = step_ff;
      cmd.ksel  = KSEL_R1;
      req_ready = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_K1;
            end
         end
         S_K1, S_K2, S_F1, S_F2: begin
            cmd.op = OP_MUL;
            unique case (state_ff)
               S_K2:    cmd.ksel = KSEL_R2;
               S_F1:    cmd.ksel = KSEL_F1;
               S_F2:    cmd.ksel = KSEL_F2;
               default: cmd.ksel = KSEL_R1;
            endcase
            if (step_ff == MulStepCrossB) begin
               step_in = MulStepLow;
               unique case (state_ff)
                  S_K1:    state_in = S_ROT;
                  S_K2:    state_in = S_APPLY;
                  S_F1:    state_in = S_FMID;
                  default: state_in = S_FEND;
               endcase
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         S_ROT: begin
            cmd.op   = OP_ROT;
            state_in = S_K2;
         end
         S_APPLY: begin
            if (status.is_full) begin
               cmd.op   = OP_MIX1;
               state_in = S_MIX2;
            end else begin
               cmd.op   = OP_TAIL;
               state_in = status.is_last ? S_FIN_A : S_IDLE;
            end
         end
         S_MIX2: begin
            cmd.op   = OP_MIX2;
            state_in = status.is_last ? S_FIN_A : S_IDLE;
         end
         S_FIN_A: begin
            cmd.op   = OP_FIN_A;
            state_in = S_FIN_B;
         end
         S_FIN_B: begin
            cmd.op   = OP_FIN_B;
            state_in = S_FLD;
         end
         S_FLD: begin
            cmd.op   = OP_FMIX_LD;
            state_in = S_F1;
         end
         S_FMID: begin
            cmd.op   = OP_FMIX_MID;
            state_in = S_F2;
         end
         S_FEND: begin
            cmd.op   = OP_FMIX_END;
            state_in = S_FIN_C;
         end
         S_FIN_C: begin
            cmd.op   = OP_FIN_C;
            state_in = S_FIN_D;
         end
         S_FIN_D: begin
            cmd.op   = OP_FIN_D;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // Wait until the result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = OP_EMIT;
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result valid: set on emit, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= MulStepLow;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // The step counter only runs inside a multiply round.
   assert property (@(posedge clock) disable iff (reset)
      (step_ff != MulStepLow) |->
         (state_ff == S_K1 || state_ff == S_K2 || state_ff == S_F1 || state_ff == S_F2))
      else $error("multiplier step active outside a multiply round");

   // A new result appears only out of the emit state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("response valid rose without an emit");

   // An accepted request always starts the first multiply round.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_K1 && step_ff == MulStepLow))
      else $error("accepted request did not start key mixing");

   // Emit never overwrites a result that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

endmodule

// File: hw/rtl/murmur3_x64_128_stream_hash.sv
// Top level of the MurmurHash3 x64-128 stream hasher: controller, datapath and ports.
//
//   channel  ports                        direction  content
//   req      req_valid/req_ready/req_data   in        one 16-byte block, count, last flag
//   rsp      rsp_valid/rsp_ready/rsp_data   out       128-bit hash and length flag
//   csr      csr_valid/csr_ready/csr_data   in        32-bit hash seed
//
// A request that is not last passes through load, a three-step round on the 32x32
// multipliers, a rotate, a second round and two lane updates; a short last block uses one
// tail update instead. A last request then goes on to the length fold, the two
// fmix64 rounds, the final adds and the emit, plus any wait for the result register.
// Reset is synchronous; it restores the seed to 10457 and clears the count, the overflow flag and the result valid.
// The result register lets the next request be taken while a result waits.
module murmur3_x64_128_stream_hash #(
   parameter int LENGTH_BITS = mm3_pkg::LengthBitsDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  mm3_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output mm3_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [31:0]     csr_data
);
   import mm3_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       seed_write;

   // The seed register takes a write in any cycle.
   assign csr_ready  = 1'b1;
   assign seed_write = csr_valid && csr_ready;

   mm3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mm3_datapath #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_data   (req_data),
      .seed_write (seed_write),
      .seed_data  (csr_data),
      .rsp_data   (rsp_data)
   );

endmodule
